[rtl/dtpc_pkg.sv]
// shared types and constants of the depth to point cloud block
package dtpc_pkg;

    // configuration register widths and port sizes
    localparam int CENTER_W   = 14;
    localparam int INV_W      = 25;
    localparam int DIM_W      = 10;
    localparam int CFG_DATA_W = 25;
    localparam int CFG_IDX_W  = 3;

    // payload widths
    localparam int DEPTH_W   = 16;
    localparam int COLOR_W   = 32;
    localparam int COORD_W   = 32;
    localparam int Z_W       = 23;
    localparam int PIX_IDX_W = 18;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd5;

    // reset values of the registers
    localparam logic [CENTER_W-1:0] CENTER_X_RST     = 14'd4096;
    localparam logic [CENTER_W-1:0] CENTER_Y_RST     = 14'd3392;
    localparam logic [INV_W-1:0]    INV_FOCAL_X_RST  = 25'd45965;
    localparam logic [INV_W-1:0]    INV_FOCAL_Y_RST  = 25'd45965;
    localparam logic [DIM_W-1:0]    FRAME_WIDTH_RST  = 10'd512;
    localparam logic [DIM_W-1:0]    FRAME_HEIGHT_RST = 10'd424;

    // shared multiplier operand widths
    localparam int MUL_A_W = 30;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // z = floor(mm * 65536 / 1000) = (mm * ceil(2^36 / 125)) >> 23
    localparam logic [MUL_A_W-1:0] Z_RECIP = 30'd549755814;
    localparam int Z_SHIFT = 23;

    // split point of the projection product before it meets z
    localparam int P_LO_W = 20;

    // rounding of the 2^-28 scaled magnitude
    localparam int ROUND_SHIFT = 28;
    localparam logic [ROUND_SHIFT-1:0] ROUND_BIAS = 28'h8000000;

    localparam logic [COORD_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] NEG_LIMIT = 32'h8000_0000;

    typedef enum logic [1:0] {
        MUL_Z,
        MUL_P,
        MUL_LO,
        MUL_HI
    } t_mul_sel;

    typedef struct packed {
        logic     capture;
        t_mul_sel mul_sel;
        logic     axis;       // 0 x, 1 y
        logic     ld_z;
        logic     ld_p;
        logic     acc_init;
        logic     acc_add;
        logic     ld_res;
    } t_cmd;

    typedef struct packed {
        logic pix_valid;
    } t_status;

endpackage

[rtl/depth_to_point_cloud.sv]
// top level: configuration registers, sequencer and datapath of the depth back-projector
//
//  channel  direction  handshake                  payload
//  input    in         i_in_valid / o_in_stall    depth_mm, depth_is_number, color_word,
//                                                 frame_start
//  output   out        o_out_valid / i_out_stall  point_x, point_y, point_z, color_out,
//                                                 point_written, pixel_index
//  config   in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
//  for a valid pixel all seven products (z scale, two offset times inverse focal, four
//  partial products with z) go through one 30x25 multiplier in turn
//  an invalid pixel (not a number, or depth of 1 mm or less) skips the multiplies
//  one request in flight; o_in_stall stays high until its result is taken
//  a stalled result holds its payload; synchronous active-low reset clears the
//  sequencer, the pixel position and the registers to their defaults
module depth_to_point_cloud #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [dtpc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [dtpc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // pixel requests
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [dtpc_pkg::DEPTH_W-1:0]         i_depth_mm,
    input  logic                                 i_depth_is_number,
    input  logic [dtpc_pkg::COLOR_W-1:0]         i_color_word,
    input  logic                                 i_frame_start,
    // point results
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [dtpc_pkg::COORD_W-1:0]  o_point_x,
    output logic signed [dtpc_pkg::COORD_W-1:0]  o_point_y,
    output logic [dtpc_pkg::Z_W-1:0]             o_point_z,
    output logic [dtpc_pkg::COLOR_W-1:0]         o_color_out,
    output logic                                 o_point_written,
    output logic [dtpc_pkg::PIX_IDX_W-1:0]       o_pixel_index
);
    import dtpc_pkg::*;

    // camera intrinsics and frame geometry
    logic [CENTER_W-1:0] r_center_x;
    logic [CENTER_W-1:0] r_center_y;
    logic [INV_W-1:0]    r_inv_focal_x;
    logic [INV_W-1:0]    r_inv_focal_y;
    logic [DIM_W-1:0]    r_frame_width;
    logic [DIM_W-1:0]    r_frame_height;

    t_cmd    cmd;
    t_status status;

    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;

    // register writes; indexes past the last register are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x     <= CENTER_X_RST;
            r_center_y     <= CENTER_Y_RST;
            r_inv_focal_x  <= INV_FOCAL_X_RST;
            r_inv_focal_y  <= INV_FOCAL_Y_RST;
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CENTER_X:     r_center_x     <= i_cfg_data[CENTER_W-1:0];
                REG_CENTER_Y:     r_center_y     <= i_cfg_data[CENTER_W-1:0];
                REG_INV_FOCAL_X:  r_inv_focal_x  <= i_cfg_data[INV_W-1:0];
                REG_INV_FOCAL_Y:  r_inv_focal_y  <= i_cfg_data[INV_W-1:0];
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer: handshakes and per-cycle datapath commands
    dtpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // position tracking, arithmetic and result holding
    dtpc_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_center_x        (r_center_x),
        .i_center_y        (r_center_y),
        .i_inv_focal_x     (r_inv_focal_x),
        .i_inv_focal_y     (r_inv_focal_y),
        .i_frame_width     (r_frame_width),
        .i_frame_height    (r_frame_height),
        .i_depth_mm        (i_depth_mm),
        .i_depth_is_number (i_depth_is_number),
        .i_color_word      (i_color_word),
        .i_frame_start     (i_frame_start),
        .o_point_x         (point_x),
        .o_point_y         (point_y),
        .o_point_z         (o_point_z),
        .o_color_out       (o_color_out),
        .o_point_written   (o_point_written),
        .o_pixel_index     (o_pixel_index)
    );

    // coordinates leave as two's complement
    assign o_point_x = signed'(point_x);
    assign o_point_y = signed'(point_y);

endmodule

[rtl/dtpc_ctrl.sv]
// sequencer that steps the shared multiplier through one pixel
module dtpc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_stall,
    input  dtpc_pkg::t_status i_status,
    output dtpc_pkg::t_cmd   o_cmd,
    output logic             o_in_stall,
    output logic             o_out_valid
);
    import dtpc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MZ,
        S_MP,
        S_LDP,
        S_LO,
        S_ACCLO,
        S_ACCHI,
        S_FIN,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_axis;
    logic   r_in_stall;
    logic   r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.mul_sel  = MUL_Z;
        o_cmd.axis     = r_axis;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
            end
            S_MZ: begin
                o_cmd.mul_sel = MUL_Z;
            end
            S_MP: begin
                o_cmd.mul_sel = MUL_P;
                o_cmd.ld_z    = !r_axis;
            end
            S_LDP: begin
                o_cmd.ld_p = 1'b1;
            end
            S_LO: begin
                o_cmd.mul_sel = MUL_LO;
            end
            S_ACCLO: begin
                o_cmd.acc_init = 1'b1;
                o_cmd.mul_sel  = MUL_HI;
            end
            S_ACCHI: begin
                o_cmd.acc_add = 1'b1;
            end
            S_FIN: begin
                o_cmd.ld_res = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 1'b0;
            r_in_stall  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state    <= S_MZ;
                        r_axis     <= 1'b0;
                        r_in_stall <= 1'b1;
                    end
                end
                S_MZ: begin
                    if (i_status.pix_valid) begin
                        r_state <= S_MP;
                    end else begin
                        r_state     <= S_OUT;
                        r_out_valid <= 1'b1;
                    end
                end
                S_MP:    r_state <= S_LDP;
                S_LDP:   r_state <= S_LO;
                S_LO:    r_state <= S_ACCLO;
                S_ACCLO: r_state <= S_ACCHI;
                S_ACCHI: r_state <= S_FIN;
                S_FIN: begin
                    if (!r_axis) begin
                        r_axis  <= 1'b1;
                        r_state <= S_MP;
                    end else begin
                        r_state     <= S_OUT;
                        r_out_valid <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b0;
                        r_in_stall  <= 1'b0;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b0;
                    r_in_stall  <= 1'b0;
                end
            endcase
        end
    end

    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;

endmodule

[rtl/dtpc_dpath.sv]
// position counters, shared multiplier, accumulator and result registers
module dtpc_dpath #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dtpc_pkg::t_cmd                    i_cmd,
    output dtpc_pkg::t_status                 o_status,
    input  logic [dtpc_pkg::CENTER_W-1:0]     i_center_x,
    input  logic [dtpc_pkg::CENTER_W-1:0]     i_center_y,
    input  logic [dtpc_pkg::INV_W-1:0]        i_inv_focal_x,
    input  logic [dtpc_pkg::INV_W-1:0]        i_inv_focal_y,
    input  logic [dtpc_pkg::DIM_W-1:0]        i_frame_width,
    input  logic [dtpc_pkg::DIM_W-1:0]        i_frame_height,
    input  logic [dtpc_pkg::DEPTH_W-1:0]      i_depth_mm,
    input  logic                              i_depth_is_number,
    input  logic [dtpc_pkg::COLOR_W-1:0]      i_color_word,
    input  logic                              i_frame_start,
    output logic [dtpc_pkg::COORD_W-1:0]      o_point_x,
    output logic [dtpc_pkg::COORD_W-1:0]      o_point_y,
    output logic [dtpc_pkg::Z_W-1:0]          o_point_z,
    output logic [dtpc_pkg::COLOR_W-1:0]      o_color_out,
    output logic                              o_point_written,
    output logic [dtpc_pkg::PIX_IDX_W-1:0]    o_pixel_index
);
    import dtpc_pkg::*;

    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int EWW = (WW > DIM_W) ? WW : DIM_W;
    localparam int EHW = (HW > DIM_W) ? HW : DIM_W;
    localparam int IW  = (RW + WW + 1 > PIX_IDX_W) ? RW + WW + 1 : PIX_IDX_W;
    localparam int AXW = CW + 4;
    localparam int AYW = RW + 4;
    localparam int DW0 = (AXW > CENTER_W) ? AXW : CENTER_W;
    localparam int DW1 = (AYW > CENTER_W) ? AYW : CENTER_W;
    localparam int DW  = (DW0 > DW1) ? DW0 : DW1;
    localparam int PW  = DW + INV_W;
    localparam int AW  = PW + Z_W;
    localparam int MW  = AW + 1 - ROUND_SHIFT;

    // position counters
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    // per-pixel working registers
    logic [DEPTH_W-1:0] r_depth;
    logic [DW-1:0]      r_adx;
    logic [DW-1:0]      r_ady;
    logic               r_neg_x;
    logic               r_neg_y;
    logic [PROD_W-1:0]  r_prod;
    logic [PW-1:0]      r_p;
    logic [AW-1:0]      r_acc;

    // result registers
    logic [COORD_W-1:0]   r_x;
    logic [COORD_W-1:0]   r_y;
    logic [Z_W-1:0]       r_z;
    logic [COLOR_W-1:0]   r_color;
    logic                 r_written;
    logic [PIX_IDX_W-1:0] r_index;

    logic [WW-1:0]      w_eff;
    logic [HW-1:0]      h_eff;
    logic [EWW-1:0]     fw_ext;
    logic [EHW-1:0]     fh_ext;
    logic [CW-1:0]      col_cur;
    logic [RW-1:0]      row_cur;
    logic [WW-1:0]      col_inc;
    logic [HW-1:0]      row_inc;
    logic [IW-1:0]      idx_full;
    logic [DW-1:0]      pos_x;
    logic [DW-1:0]      pos_y;
    logic [DW-1:0]      cen_x;
    logic [DW-1:0]      cen_y;
    logic               pix_ok;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [AW:0]        rnd;
    logic [MW-1:0]      mag;
    logic               neg;
    logic [COORD_W-1:0] res;

    // frame size clamp: zero acts as one, oversize acts as the maximum
    always_comb begin
        fw_ext = EWW'(i_frame_width);
        fh_ext = EHW'(i_frame_height);
        if (fw_ext == '0) begin
            w_eff = WW'(1);
        end else if (fw_ext > EWW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(fw_ext);
        end
        if (fh_ext == '0) begin
            h_eff = HW'(1);
        end else if (fh_ext > EHW'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(fh_ext);
        end
    end

    always_comb begin
        col_cur = (i_frame_start || WW'(r_col) >= w_eff) ? '0 : r_col;
        row_cur = (i_frame_start || HW'(r_row) >= h_eff) ? '0 : r_row;
        col_inc = WW'(col_cur) + WW'(1);
        row_inc = HW'(row_cur) + HW'(1);
        idx_full = IW'(row_cur) * IW'(w_eff) + IW'(col_cur);
        // pixel center in 1/16 pixel
        pos_x = DW'({col_cur, 4'b1000});
        pos_y = DW'({row_cur, 4'b1000});
        cen_x = DW'(i_center_x);
        cen_y = DW'(i_center_y);
        pix_ok = i_depth_is_number && (i_depth_mm > DEPTH_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.capture) begin
            if (col_inc >= w_eff) begin
                r_col <= '0;
                r_row <= (row_inc >= h_eff) ? '0 : RW'(row_inc);
            end else begin
                r_col <= CW'(col_inc);
                r_row <= row_cur;
            end
        end
    end

    // shared multiplier operand select
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_Z: begin
                mul_a = Z_RECIP;
                mul_b = MUL_B_W'(r_depth);
            end
            MUL_P: begin
                mul_a = i_cmd.axis ? MUL_A_W'(r_ady) : MUL_A_W'(r_adx);
                mul_b = i_cmd.axis ? MUL_B_W'(i_inv_focal_y) : MUL_B_W'(i_inv_focal_x);
            end
            MUL_LO: begin
                mul_a = MUL_A_W'(r_p[P_LO_W-1:0]);
                mul_b = MUL_B_W'(r_z);
            end
            MUL_HI: begin
                mul_a = MUL_A_W'(r_p[PW-1:P_LO_W]);
                mul_b = MUL_B_W'(r_z);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // round half away from zero on the magnitude, then saturate
    always_comb begin
        rnd = (AW+1)'(r_acc) + (AW+1)'(ROUND_BIAS);
        mag = rnd[AW:ROUND_SHIFT];
        neg = i_cmd.axis ? r_neg_y : r_neg_x;
        if (neg) begin
            res = (mag > MW'(NEG_LIMIT)) ? NEG_LIMIT : COORD_W'(0) - mag[COORD_W-1:0];
        end else begin
            res = (mag > MW'(POS_LIMIT)) ? POS_LIMIT : mag[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (i_cmd.capture) begin
            r_depth   <= i_depth_mm;
            r_written <= pix_ok;
            r_color   <= pix_ok ? i_color_word : '0;
            r_index   <= idx_full[PIX_IDX_W-1:0];
            r_x       <= '0;
            r_y       <= '0;
            r_z       <= '0;
            r_adx     <= (pos_x >= cen_x) ? pos_x - cen_x : cen_x - pos_x;
            r_ady     <= (pos_y >= cen_y) ? pos_y - cen_y : cen_y - pos_y;
            // x points the other way from the column offset
            r_neg_x   <= (pos_x >= cen_x);
            r_neg_y   <= (pos_y < cen_y);
        end
        if (i_cmd.ld_z) begin
            r_z <= r_prod[Z_SHIFT+Z_W-1:Z_SHIFT];
        end
        if (i_cmd.ld_p) begin
            r_p <= r_prod[PW-1:0];
        end
        if (i_cmd.acc_init) begin
            r_acc <= AW'(r_prod);
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + (AW'(r_prod) << P_LO_W);
        end
        if (i_cmd.ld_res) begin
            if (i_cmd.axis) begin
                r_y <= res;
            end else begin
                r_x <= res;
            end
        end
    end

    assign o_status.pix_valid = r_written;
    assign o_point_x       = r_x;
    assign o_point_y       = r_y;
    assign o_point_z       = r_z;
    assign o_color_out     = r_color;
    assign o_point_written = r_written;
    assign o_pixel_index   = r_index;

endmodule

[rtl/dtpc_checker.sv]
// port-level checks of the depth to point cloud block, bound to the top level
module dtpc_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_stall,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic signed [dtpc_pkg::COORD_W-1:0]  o_point_x,
    input logic signed [dtpc_pkg::COORD_W-1:0]  o_point_y,
    input logic [dtpc_pkg::Z_W-1:0]             o_point_z,
    input logic [dtpc_pkg::COLOR_W-1:0]         o_color_out,
    input logic                                 o_point_written,
    input logic [dtpc_pkg::PIX_IDX_W-1:0]       o_pixel_index
);
    import dtpc_pkg::*;

    // one request at a time: a pending result keeps the input closed
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("result pending while input open");

    // an accepted request closes the input on the next cycle
    a_accept_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open right after accept");

    // no repeated results: a taken result is not shown again
    a_no_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) |=> !o_out_valid)
        else $error("result repeated");

    // unwritten points carry zero coordinates and color
    a_unwritten_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_point_written) |->
            (o_point_x == '0) && (o_point_y == '0) && (o_point_z == '0) &&
            (o_color_out == '0))
        else $error("unwritten point with nonzero payload");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            o_out_valid && $stable(o_point_x) && $stable(o_point_y) &&
            $stable(o_pixel_index))
        else $error("stalled result changed");

endmodule

bind depth_to_point_cloud dtpc_checker u_dtpc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_point_x       (o_point_x),
    .o_point_y       (o_point_y),
    .o_point_z       (o_point_z),
    .o_color_out     (o_color_out),
    .o_point_written (o_point_written),
    .o_pixel_index   (o_pixel_index)
);
